// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the integer formatter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ITA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ita assertion failed");
`define ITA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ita assertion failed");
`else
`define ITA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ITA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Types, constants and helpers shared by the integer formatter modules.
// ----------------------------------------------------------------------------
package ita_pkg;

   localparam int VALUE_W         = 64;
   localparam int FIELD_W         = 6;
   localparam int DIG_MAX         = 22;
   localparam int DIG_IDX_W       = $clog2(DIG_MAX);
   localparam int MAX_WIDTH_DEF   = 63;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_A_UPPER = 8'h41;
   localparam logic [7:0] CHAR_A_LOWER = 8'h61;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               is_signed;
      logic [1:0]         radix_sel;
      logic               upper_case;
      logic [FIELD_W-1:0] field_width;
      logic [FIELD_W-1:0] min_digits;
      logic               digits_given;
      logic               flush_left;
      logic               plus_flag;
      logic               space_flag;
      logic               zero_flag;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_W-1:0] mag;
      logic               has_sign;
      logic [7:0]         sign_char;
      logic [1:0]         radix;
      logic               upper;
      logic [FIELD_W-1:0] fw;
      logic [FIELD_W-1:0] prec;
      logic               pgiven;
      logic               left;
      logic               zero_pad;
   } job_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] letter_base;
      letter_base = upper ? CHAR_A_UPPER : CHAR_A_LOWER;
      if (d < 4'd10) begin
         return CHAR_ZERO + {4'b0, d};
      end
      return letter_base + {4'b0, d} - 8'd10;
   endfunction

endpackage

// File: rtl/core/ita_front.sv
// ----------------------------------------------------------------------------
// ita_front
// Classifies an incoming beat: sign prefix, magnitude, radix and padding mode.
// ----------------------------------------------------------------------------
module ita_front (
   input  logic             push,
   input  logic             q_full,
   input  ita_pkg::req_type req_data,
   output logic             job_push,
   output ita_pkg::job_type job
);

   logic negative;

   assign negative = req_data.is_signed & req_data.value[ita_pkg::VALUE_W-1];
   assign job_push = push & ~q_full;

   always_comb begin
      job.mag       = negative ? (ita_pkg::VALUE_W'(0) - req_data.value) : req_data.value;
      job.has_sign  = negative |
                      (req_data.is_signed & (req_data.plus_flag | req_data.space_flag));
      if (negative) begin
         job.sign_char = ita_pkg::CHAR_MINUS;
      end else if (req_data.plus_flag) begin
         job.sign_char = ita_pkg::CHAR_PLUS;
      end else begin
         job.sign_char = ita_pkg::CHAR_SPACE;
      end
      case (req_data.radix_sel)
         ita_pkg::RADIX_DEC: job.radix = ita_pkg::RADIX_DEC;
         ita_pkg::RADIX_OCT: job.radix = ita_pkg::RADIX_OCT;
         default:            job.radix = ita_pkg::RADIX_HEX;
      endcase
      job.upper    = req_data.upper_case;
      job.fw       = req_data.field_width;
      job.prec     = req_data.min_digits;
      job.pgiven   = req_data.digits_given;
      job.left     = req_data.flush_left;
      job.zero_pad = req_data.zero_flag & ~req_data.flush_left & ~req_data.digits_given;
   end

endmodule

// File: rtl/core/ita_queue.sv
// ----------------------------------------------------------------------------
// ita_queue
// Short first-in first-out buffer of classified jobs between front and back.
// ----------------------------------------------------------------------------
module ita_queue #(
   parameter int DEPTH = ita_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  ita_pkg::job_type wr_data,
   output logic             q_full,
   output logic             q_empty,
   input  logic             rd_en,
   output ita_pkg::job_type rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ita_pkg::job_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en & ~q_full;
   assign do_rd   = rd_en & ~q_empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr & ~do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd & ~do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/ita_back.sv
// ----------------------------------------------------------------------------
// ita_back
// Converts the magnitude to digits, sizes the field and emits its characters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ita_back #(
   parameter int MAX_WIDTH = ita_pkg::MAX_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  ita_pkg::job_type job,
   output logic             job_take,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output ita_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_WIDTH + 2);
   localparam int IDX_W = ita_pkg::DIG_IDX_W;
   localparam int VW    = ita_pkg::VALUE_W;
   localparam int BIT_W = $clog2(VW);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DABBLE, ST_SCAN, ST_SIZE, ST_PLAN, ST_BOUND, ST_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [VW-1:0]              mag_ff, mag_in;
   logic [3:0]                 digits_ff [ita_pkg::DIG_MAX];
   logic [3:0]                 digits_in [ita_pkg::DIG_MAX];
   logic [IDX_W-1:0]           dig_idx_ff, dig_idx_in;
   logic [BIT_W-1:0]           bit_cnt_ff, bit_cnt_in;
   logic                       has_sign_ff, has_sign_in;
   logic [7:0]                 sign_char_ff, sign_char_in;
   logic                       is_dec_ff, is_dec_in;
   logic                       upper_ff, upper_in;
   logic [ita_pkg::FIELD_W-1:0] fw_ff, fw_in;
   logic [ita_pkg::FIELD_W-1:0] prec_ff, prec_in;
   logic                       pgiven_ff, pgiven_in;
   logic                       left_ff, left_in;
   logic                       zero_pad_ff, zero_pad_in;
   logic [CNT_W-1:0]           mindig_ff, mindig_in;
   logic [CNT_W-1:0]           fwc_ff, fwc_in;
   logic [CNT_W-1:0]           total_ff, total_in;
   logic [CNT_W-1:0]           pad_ff, pad_in;
   logic [CNT_W-1:0]           b1_ff, b1_in;
   logic [CNT_W-1:0]           b2_ff, b2_in;
   logic [CNT_W-1:0]           b3_ff, b3_in;
   logic [CNT_W-1:0]           b4_ff, b4_in;
   logic [CNT_W-1:0]           pos_ff, pos_in;
   logic                       out_valid_ff, out_valid_in;
   ita_pkg::rsp_type           out_data_ff, out_data_in;

   logic [VW+23:0]             hex_ext;
   logic [VW+1:0]              oct_ext;
   logic [3:0]                 adj [ita_pkg::DIG_MAX];
   logic [3:0]                 shifted [ita_pkg::DIG_MAX];
   logic [3:0]                 cur_dig;
   logic [CNT_W-1:0]           nd;
   logic [CNT_W-1:0]           fw_c, prec_c, mindig_base, body, zc;
   logic [CNT_W-1:0]           dig_left;
   logic                       emit, last_char, bcd_ok, dig_slot;
   logic [7:0]                 emit_char;

   assign hex_ext   = {24'b0, job.mag};
   assign oct_ext   = {2'b0, job.mag};
   assign cur_dig   = digits_ff[dig_idx_ff];
   assign nd        = CNT_W'(dig_idx_ff) + 1'b1;
   assign job_take  = (state_ff == ST_IDLE) & job_valid;
   assign emit      = (state_ff == ST_EMIT) & (~out_valid_ff | rsp_pop);
   assign last_char = (pos_ff == total_ff - 1'b1);
   assign dig_slot  = (pos_ff >= b3_ff) && (pos_ff < b4_ff);
   assign dig_left  = b4_ff - pos_ff - 1'b1;
   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      for (int i = 0; i < ita_pkg::DIG_MAX; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
      shifted[0] = {adj[0][2:0], mag_ff[VW-1]};
      for (int i = 1; i < ita_pkg::DIG_MAX; i++) begin
         shifted[i] = {adj[i][2:0], adj[i-1][3]};
      end
      bcd_ok = 1'b1;
      for (int i = 0; i < ita_pkg::DIG_MAX; i++) begin
         if (digits_ff[i] > 4'd9) begin
            bcd_ok = 1'b0;
         end
      end
   end

   always_comb begin
      fw_c        = (int'(fw_ff) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(fw_ff);
      prec_c      = (int'(prec_ff) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(prec_ff);
      mindig_base = pgiven_ff ? prec_c : CNT_W'(1);
      body        = mindig_ff + CNT_W'(has_sign_ff);
      zc          = (mindig_ff - nd) + (zero_pad_ff ? pad_ff : '0);
      if (pos_ff < b1_ff) begin
         emit_char = ita_pkg::CHAR_SPACE;
      end else if (pos_ff < b2_ff) begin
         emit_char = sign_char_ff;
      end else if (pos_ff < b3_ff) begin
         emit_char = ita_pkg::CHAR_ZERO;
      end else if (pos_ff < b4_ff) begin
         emit_char = ita_pkg::digit_char(cur_dig, upper_ff);
      end else begin
         emit_char = ita_pkg::CHAR_SPACE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      digits_in    = digits_ff;
      dig_idx_in   = dig_idx_ff;
      bit_cnt_in   = bit_cnt_ff;
      has_sign_in  = has_sign_ff;
      sign_char_in = sign_char_ff;
      is_dec_in    = is_dec_ff;
      upper_in     = upper_ff;
      fw_in        = fw_ff;
      prec_in      = prec_ff;
      pgiven_in    = pgiven_ff;
      left_in      = left_ff;
      zero_pad_in  = zero_pad_ff;
      mindig_in    = mindig_ff;
      fwc_in       = fwc_ff;
      total_in     = total_ff;
      pad_in       = pad_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      pos_in       = pos_ff;
      out_valid_in = rsp_pop ? 1'b0 : out_valid_ff;
      out_data_in  = out_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               mag_in       = job.mag;
               has_sign_in  = job.has_sign;
               sign_char_in = job.sign_char;
               is_dec_in    = (job.radix == ita_pkg::RADIX_DEC);
               upper_in     = job.upper;
               fw_in        = job.fw;
               prec_in      = job.prec;
               pgiven_in    = job.pgiven;
               left_in      = job.left;
               zero_pad_in  = job.zero_pad;
               bit_cnt_in   = '0;
               dig_idx_in   = IDX_W'(ita_pkg::DIG_MAX - 1);
               for (int i = 0; i < ita_pkg::DIG_MAX; i++) begin
                  case (job.radix)
                     ita_pkg::RADIX_DEC: digits_in[i] = 4'd0;
                     ita_pkg::RADIX_OCT: digits_in[i] = {1'b0, oct_ext[3*i +: 3]};
                     default:            digits_in[i] = hex_ext[4*i +: 4];
                  endcase
               end
               state_in = (job.radix == ita_pkg::RADIX_DEC) ? ST_DABBLE : ST_SCAN;
            end
         end
         ST_DABBLE: begin
            digits_in  = shifted;
            mag_in     = {mag_ff[VW-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_W'(VW - 1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((cur_dig != 4'd0) || (dig_idx_ff == '0)) begin
               state_in = ST_SIZE;
            end else begin
               dig_idx_in = dig_idx_ff - 1'b1;
            end
         end
         ST_SIZE: begin
            fwc_in    = fw_c;
            mindig_in = (mindig_base > nd) ? mindig_base : nd;
            state_in  = ST_PLAN;
         end
         ST_PLAN: begin
            total_in = (body > fwc_ff) ? body : fwc_ff;
            pad_in   = ((body > fwc_ff) ? body : fwc_ff) - body;
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            b1_in    = (~left_ff & ~zero_pad_ff) ? pad_ff : '0;
            b2_in    = ((~left_ff & ~zero_pad_ff) ? pad_ff : '0) + CNT_W'(has_sign_ff);
            b3_in    = ((~left_ff & ~zero_pad_ff) ? pad_ff : '0) + CNT_W'(has_sign_ff) + zc;
            b4_in    = total_ff - (left_ff ? pad_ff : '0);
            pos_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit) begin
               out_valid_in         = 1'b1;
               out_data_in.out_char = emit_char;
               out_data_in.last     = last_char;
               pos_in               = pos_ff + 1'b1;
               if (dig_slot && (dig_idx_ff != '0)) begin
                  dig_idx_in = dig_idx_ff - 1'b1;
               end
               if (last_char) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      digits_ff    <= digits_in;
      dig_idx_ff   <= dig_idx_in;
      bit_cnt_ff   <= bit_cnt_in;
      has_sign_ff  <= has_sign_in;
      sign_char_ff <= sign_char_in;
      is_dec_ff    <= is_dec_in;
      upper_ff     <= upper_in;
      fw_ff        <= fw_in;
      prec_ff      <= prec_in;
      pgiven_ff    <= pgiven_in;
      left_ff      <= left_in;
      zero_pad_ff  <= zero_pad_in;
      mindig_ff    <= mindig_in;
      fwc_ff       <= fwc_in;
      total_ff     <= total_in;
      pad_ff       <= pad_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      b3_ff        <= b3_in;
      b4_ff        <= b4_in;
      pos_ff       <= pos_in;
      out_data_ff  <= out_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `ITA_ASSERT_IMPL(a_emit_in_field, clock, reset, state_ff == ST_EMIT, pos_ff < total_ff)
   `ITA_ASSERT_IMPL(a_bcd_digits, clock, reset, (state_ff == ST_SCAN) && is_dec_ff, bcd_ok)
   `ITA_ASSERT_NEXT(a_last_ends_item, clock, reset, emit && last_char, state_ff == ST_IDLE)
   `ITA_ASSERT_IMPL(a_digit_index, clock, reset, emit && dig_slot, CNT_W'(dig_idx_ff) == dig_left)

endmodule

// File: rtl/core/integer_to_ascii_formatter.sv
// The back end loads an accepted request from the queue, runs the decimal conversion
// (none for octal or hex), scans for the leading digit, sizes the field in its SIZE, PLAN
// and BOUND states and registers the first character; the field then leaves one per cycle
// while the result register is empty or popped. The next job is taken once a field ends.
// Reset is synchronous and active high; it empties the queue and the result register.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a 64-bit integer as a printf-style ASCII field, one character a beat.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
   parameter int MAX_WIDTH   = ita_pkg::MAX_WIDTH_DEF,
   parameter int QUEUE_DEPTH = ita_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ita_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output ita_pkg::rsp_type rsp_data
);

   ita_pkg::job_type front_job;
   ita_pkg::job_type queue_job;
   logic             job_push;
   logic             q_empty;
   logic             job_take;

   ita_front u_front (
      .push     (push),
      .q_full   (full),
      .req_data (req_data),
      .job_push (job_push),
      .job      (front_job)
   );

   ita_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (front_job),
      .q_full  (full),
      .q_empty (q_empty),
      .rd_en   (job_take),
      .rd_data (queue_job)
   );

   ita_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (~q_empty),
      .job       (queue_job),
      .job_take  (job_take),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/integer_to_ascii_formatter_tb.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Drives formatted-integer requests into the formatter, predicts every ASCII
// character of each field and checks the character stream beat by beat.
// Directed fields cover the extremes, each radix, signs, flags and padding
// modes. Random fields follow, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] RADIX_SPARE = 2'd3;
   localparam int RANDOM_ITEMS   = 175;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int REPORT_LIMIT   = 10;

   class field_scoreboard;
      ita_pkg::rsp_type expected_chars[$];
      int               mismatches;

      function int pending();
         return expected_chars.size();
      endfunction

      function void note_request(ita_pkg::req_type r);
         logic [63:0]      mag;
         logic [63:0]      base;
         logic [3:0]       d;
         logic [7:0]       sign_ch;
         logic [7:0]       digs[$];
         logic [7:0]       text[$];
         bit               has_sign;
         int               mindig;
         int               body;
         int               total;
         int               pad;
         ita_pkg::rsp_type beat;
         mag = r.value;
         has_sign = 1'b0;
         sign_ch = ita_pkg::CHAR_SPACE;
         case (r.radix_sel)
            ita_pkg::RADIX_DEC: base = 64'd10;
            ita_pkg::RADIX_OCT: base = 64'd8;
            default:            base = 64'd16;
         endcase
         if (r.is_signed) begin
            if (r.value[63]) begin
               has_sign = 1'b1;
               sign_ch = ita_pkg::CHAR_MINUS;
               mag = 64'd0 - r.value;
            end else if (r.plus_flag) begin
               has_sign = 1'b1;
               sign_ch = ita_pkg::CHAR_PLUS;
            end else if (r.space_flag) begin
               has_sign = 1'b1;
               sign_ch = ita_pkg::CHAR_SPACE;
            end
         end
         do begin
            d = 4'(mag % base);
            if (d < 4'd10) begin
               digs.push_front(ita_pkg::CHAR_ZERO + {4'b0, d});
            end else begin
               digs.push_front((r.upper_case ? ita_pkg::CHAR_A_UPPER : ita_pkg::CHAR_A_LOWER)
                               + {4'b0, d} - 8'd10);
            end
            mag = mag / base;
         end while (mag != 0 && digs.size() < ita_pkg::DIG_MAX);
         mindig = r.digits_given ? int'(r.min_digits) : 1;
         if (mindig < digs.size()) mindig = digs.size();
         body = mindig + (has_sign ? 1 : 0);
         total = (body > int'(r.field_width)) ? body : int'(r.field_width);
         pad = total - body;
         if (r.zero_flag && !r.flush_left && !r.digits_given) begin
            if (has_sign) text.push_back(sign_ch);
            repeat (pad + mindig - digs.size()) text.push_back(ita_pkg::CHAR_ZERO);
         end else begin
            if (!r.flush_left) repeat (pad) text.push_back(ita_pkg::CHAR_SPACE);
            if (has_sign) text.push_back(sign_ch);
            repeat (mindig - digs.size()) text.push_back(ita_pkg::CHAR_ZERO);
         end
         foreach (digs[i]) text.push_back(digs[i]);
         if (r.flush_left) repeat (pad) text.push_back(ita_pkg::CHAR_SPACE);
         foreach (text[i]) begin
            beat.out_char = text[i];
            beat.last = (i == text.size() - 1);
            expected_chars.push_back(beat);
         end
      endfunction

      function void check_response(ita_pkg::rsp_type got);
         ita_pkg::rsp_type want;
         if (expected_chars.size() == 0) begin
            if (mismatches < REPORT_LIMIT) begin
               $display("unexpected beat: char=%h last=%b", got.out_char, got.last);
            end
            mismatches++;
            return;
         end
         want = expected_chars.pop_front();
         if (got.out_char !== want.out_char || got.last !== want.last) begin
            if (mismatches < REPORT_LIMIT) begin
               $display("mismatch: expected char=%h last=%b, got char=%h last=%b",
                        want.out_char, want.last, got.out_char, got.last);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             push;
   logic             full;
   ita_pkg::req_type req_data;
   logic             empty;
   logic             pop;
   ita_pkg::rsp_type rsp_data;

   field_scoreboard chars;
   int              tx_calm;
   int              rx_calm;
   int              idle_cycles;

   integer_to_ascii_formatter i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm = $urandom_range(10, 60);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic ita_pkg::req_type make_req(logic [63:0] value, int sgn,
                                                 logic [1:0] radix, int upper, int fw,
                                                 int prec, int pg, int left, int plus,
                                                 int space, int zero);
      ita_pkg::req_type r;
      r.value = value;
      r.is_signed = 1'(sgn);
      r.radix_sel = radix;
      r.upper_case = 1'(upper);
      r.field_width = 6'(fw);
      r.min_digits = 6'(prec);
      r.digits_given = 1'(pg);
      r.flush_left = 1'(left);
      r.plus_flag = 1'(plus);
      r.space_flag = 1'(space);
      r.zero_flag = 1'(zero);
      return r;
   endfunction

   function automatic int random_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 12);
      if (roll < 95) return $urandom_range(0, 30);
      return $urandom_range(0, 63);
   endfunction

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      int          k;
      k = $urandom_range(0, 63);
      case ($urandom_range(0, 6))
         0: v = {$urandom(), $urandom()};
         1: v = 64'($urandom_range(0, 1000));
         2: v = 64'd0 - 64'($urandom_range(1, 1000));
         3: v = 64'd1 << k;
         4: v = (64'd1 << k) - 64'd1;
         5: v = 64'($urandom());
         default: begin
            case ($urandom_range(0, 3))
               0: v = 64'd0;
               1: v = {1'b1, 63'd0};
               2: v = {1'b0, {63{1'b1}}};
               default: v = {64{1'b1}};
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic ita_pkg::req_type random_request();
      return make_req(random_value(), $urandom_range(0, 1), 2'($urandom_range(0, 3)),
                      $urandom_range(0, 1), random_size(), random_size(),
                      $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 1));
   endfunction

   task automatic send_request(ita_pkg::req_type r);
      int          gap;
      logic [95:0] noise;
      gap = pick_gap(tx_calm);
      repeat (gap) begin
         @(negedge clock);
         noise = {$urandom(), $urandom(), $urandom()};
         push <= 1'b0;
         req_data <= noise[$bits(ita_pkg::req_type)-1:0];
      end
      @(negedge clock);
      push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      chars.note_request(r);
   endtask

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("integer_to_ascii_formatter_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int gap;
      pop = 1'b0;
      rx_calm = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = pick_gap(rx_calm);
         repeat (gap) begin
            @(negedge clock);
            pop <= 1'b0;
         end
         @(negedge clock);
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         chars.check_response(rsp_data);
      end
   end

   initial begin
      ita_pkg::req_type directed[$];
      chars = new();
      tx_calm = 0;
      idle_cycles = 0;
      reset = 1'b1;
      push = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_req(64'd0, 0, ita_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_req(64'd0, 1, ita_pkg::RADIX_DEC, 0, 0, 0, 1, 0, 0, 0, 0));
      directed.push_back(make_req({64{1'b1}}, 0, ita_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 1, 1,
                                  0));
      directed.push_back(make_req({64{1'b1}}, 0, ita_pkg::RADIX_OCT, 0, 0, 0, 0, 0, 0, 0,
                                  0));
      directed.push_back(make_req({64{1'b1}}, 0, ita_pkg::RADIX_HEX, 1, 0, 0, 0, 0, 0, 0,
                                  0));
      directed.push_back(make_req(64'hABCD_EF01_2345_6789, 0, ita_pkg::RADIX_HEX, 0, 0, 0,
                                  0, 0, 0, 0, 0));
      directed.push_back(make_req({1'b1, 63'd0}, 1, ita_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 0,
                                  0, 0));
      directed.push_back(make_req({1'b1, 63'd0}, 1, ita_pkg::RADIX_HEX, 1, 0, 0, 0, 0, 0,
                                  0, 0));
      directed.push_back(make_req({64{1'b1}}, 1, ita_pkg::RADIX_HEX, 0, 0, 0, 0, 0, 1, 0,
                                  0));
      directed.push_back(make_req({64{1'b1}}, 1, ita_pkg::RADIX_OCT, 0, 0, 0, 0, 0, 0, 0,
                                  0));
      directed.push_back(make_req(64'd42, 1, ita_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(64'd42, 1, ita_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 0, 1, 0));
      directed.push_back(make_req(64'd42, 1, ita_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 1, 1, 0));
      directed.push_back(make_req(64'd42, 0, ita_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 1, 1, 0));
      directed.push_back(make_req(64'd0 - 64'd17, 1, ita_pkg::RADIX_DEC, 0, 20, 0, 0, 0, 0,
                                  0, 1));
      directed.push_back(make_req(64'd17, 1, ita_pkg::RADIX_DEC, 0, 20, 0, 0, 1, 1, 0, 1));
      directed.push_back(make_req(64'd17, 1, ita_pkg::RADIX_DEC, 0, 20, 5, 1, 0, 0, 1, 1));
      directed.push_back(make_req(64'd255, 0, ita_pkg::RADIX_HEX, 1, 12, 6, 1, 0, 0, 0, 0));
      directed.push_back(make_req(64'd255, 0, ita_pkg::RADIX_HEX, 0, 63, 0, 0, 1, 0, 0, 0));
      directed.push_back(make_req(64'd0 - 64'd5, 1, ita_pkg::RADIX_DEC, 0, 63, 63, 1, 0, 0,
                                  0, 0));
      directed.push_back(make_req(64'd0, 0, ita_pkg::RADIX_DEC, 0, 63, 0, 1, 0, 0, 0, 1));
      directed.push_back(make_req(64'hDEAD_BEEF, 0, RADIX_SPARE, 1, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_req(64'd0 - 64'd1, 1, RADIX_SPARE, 0, 3, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_req({64{1'b1}}, 1, RADIX_SPARE, 1, 63, 63, 1, 1, 1, 1, 1));
      directed.push_back(make_req(64'd7, 1, ita_pkg::RADIX_OCT, 0, 63, 0, 0, 0, 0, 1, 1));

      foreach (directed[i]) send_request(directed[i]);
      repeat (RANDOM_ITEMS) send_request(random_request());
      @(negedge clock);
      push <= 1'b0;

      while (chars.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (chars.mismatches == 0 && chars.pending() == 0) begin
         $display("integer_to_ascii_formatter_tb: done, clean");
      end else begin
         $display("integer_to_ascii_formatter_tb: done, errors");
      end
      $finish;
   end

endmodule
